// ===== hdl/threshold_leader_clustering_macros.svh =====
// ----------------------------------------------------------------------------
// threshold leader clustering assertion macros
// shared property forms for the port checker, clocked on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef THRESHOLD_LEADER_CLUSTERING_MACROS_SVH
`define THRESHOLD_LEADER_CLUSTERING_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define TLC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TLC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/tlc_pkg.sv =====
// ----------------------------------------------------------------------------
// tlc_pkg
// shared types and constants of the threshold leader clustering block
// ----------------------------------------------------------------------------
`default_nettype none

package tlc_pkg;

  // result status codes
  typedef enum logic [2:0] {
    ST_NEW       = 3'd0,
    ST_JOINED    = 3'd1,
    ST_AMBIGUOUS = 3'd2,
    ST_FULL      = 3'd3,
    ST_IGNORED   = 3'd4,
    ST_READ_DONE = 3'd5
  } status_t;

  // input opcodes
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CIRCULAR  = 1'd1;

  // register reset values
  localparam int unsigned THRESHOLD_RESET = 3277;
  localparam logic        CIRCULAR_RESET  = 1'b0;

  // cluster size tally limits
  localparam int unsigned NUM_TALLIES = 4;
  localparam int unsigned TALLY_LIMITS [NUM_TALLIES] = '{10, 20, 50, 100};

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_RDWAIT,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } ctl_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic read_issue;
    logic scan_clear;
    logic scan_issue;
    logic finish;
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic op_read;
    logic stop;
    logic scan_done;
    logic busy;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/tlc_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlc_ctrl
// sequencer: takes a word, runs the table scan or entry read (an add after a stop skips both), then commits
// ----------------------------------------------------------------------------
`default_nettype none

module tlc_ctrl
  import tlc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire dp_status_t stat,
  output ctl_cmd_t        cmd
);

  ctl_state_t state;
  ctl_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.op_read) begin
          cmd.read_issue = 1'b1;
          state_next     = S_RDWAIT;
        end else if (stat.stop) begin
          state_next = S_FINISH;
        end else begin
          cmd.scan_clear = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_RDWAIT: begin
        state_next = S_FINISH;
      end
      S_SCAN: begin
        // one leader read per cycle until every stored entry is issued
        if (!stat.scan_done) begin
          cmd.scan_issue = 1'b1;
        end else begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!stat.busy) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        // wait for the output register to free up
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/tlc_datapath.sv =====
// ----------------------------------------------------------------------------
// tlc_datapath
// leader and count tables, compare pipeline, running totals, result register
// ----------------------------------------------------------------------------
`default_nettype none

module tlc_datapath
  import tlc_pkg::*;
#(
  parameter int unsigned MAX_CLUSTERS = 64,
  parameter int unsigned VALUE_BITS   = 16,
  parameter int unsigned COUNT_BITS   = 20,
  localparam int unsigned IW = $clog2(MAX_CLUSTERS),
  localparam int unsigned TW = $clog2(MAX_CLUSTERS + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  wire logic [VALUE_BITS-1:0]         cfg_data,
  // input word fields
  input  wire logic                          in_opcode,
  input  wire logic [VALUE_BITS-1:0]         in_opinion,
  input  wire logic [IW-1:0]                 in_entry_index,
  // control
  input  wire ctl_cmd_t                      cmd,
  output dp_status_t                         stat,
  // result register
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output status_t                            out_status,
  output logic [IW-1:0]                      out_cluster_index,
  output logic [VALUE_BITS-1:0]              out_entry_value,
  output logic [COUNT_BITS-1:0]              out_entry_count,
  output logic [TW-1:0]                      out_clusters_total,
  output logic [NUM_TALLIES-1:0][TW-1:0]     out_tallies,
  output logic                               out_not_converged
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  // configuration registers
  logic [VALUE_BITS-1:0] threshold;
  logic                  circular;

  // captured input word
  logic                  item_op;
  logic [VALUE_BITS-1:0] item_val;
  logic [IW-1:0]         item_idx;

  // tables and their registered read data
  logic [VALUE_BITS-1:0] leader_mem [MAX_CLUSTERS];
  logic [COUNT_BITS-1:0] count_mem  [MAX_CLUSTERS];
  logic [VALUE_BITS-1:0] leader_q;
  logic [COUNT_BITS-1:0] count_q;

  // running state
  logic [TW-1:0]                  total;
  logic [NUM_TALLIES-1:0][TW-1:0] tally;
  logic                           stop;
  logic [TW-1:0]                  scan_cnt;
  logic [1:0]                     match_n;
  logic [IW-1:0]                  first_idx;

  // compare pipeline
  logic                  p1_valid;
  logic [IW-1:0]         p1_addr;
  logic                  p2_valid;
  logic [IW-1:0]         p2_addr;
  logic [VALUE_BITS-1:0] p2_dist;
  logic [COUNT_BITS-1:0] p2_cnt;

  // combinational
  logic                  rd_en;
  logic [IW-1:0]         rd_addr;
  logic [VALUE_BITS:0]   diff;
  logic [VALUE_BITS:0]   diff_neg;
  logic [VALUE_BITS-1:0] mag;
  logic [VALUE_BITS-1:0] wrap_dist;
  logic [VALUE_BITS-1:0] lead_dist;
  logic                  hit;
  logic                  bump_we;
  logic [COUNT_BITS-1:0] bumped;
  logic                  cnt_we;
  logic [IW-1:0]         cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata;
  status_t               res_status;
  logic [IW-1:0]         res_idx;
  logic [VALUE_BITS-1:0] res_val;
  logic [COUNT_BITS-1:0] res_cnt;
  logic                  add_new;
  logic                  set_stop;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= VALUE_BITS'(THRESHOLD_RESET);
      circular  <= CIRCULAR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: threshold <= cfg_data;
        REG_CIRCULAR:  circular  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input word capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_op  <= in_opcode;
      item_val <= in_opinion;
      item_idx <= in_entry_index;
    end
  end

  // table read port: entry read or scan address
  assign rd_en   = cmd.read_issue | cmd.scan_issue;
  assign rd_addr = cmd.read_issue ? item_idx : scan_cnt[IW-1:0];

  // count write port: new cluster or saturating bump
  assign cnt_we    = (cmd.finish & add_new) | bump_we;
  assign cnt_waddr = (cmd.finish & add_new) ? total[IW-1:0] : p2_addr;
  assign cnt_wdata = (cmd.finish & add_new) ? COUNT_BITS'(1) : bumped;

  // leader table
  always_ff @(posedge clk) begin
    if (cmd.finish && add_new) begin
      leader_mem[total[IW-1:0]] <= item_val;
    end
    if (rd_en) begin
      leader_q <= leader_mem[rd_addr];
    end
  end

  // count table
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      count_mem[cnt_waddr] <= cnt_wdata;
    end
    if (rd_en) begin
      count_q <= count_mem[rd_addr];
    end
  end

  // scan address counter
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt <= '0;
    end else if (cmd.scan_clear) begin
      scan_cnt <= '0;
    end else if (cmd.scan_issue) begin
      scan_cnt <= scan_cnt + 1'b1;
    end
  end

  // distance: linear is |d|, circular folds anything past one half
  assign diff      = {1'b0, leader_q} - {1'b0, item_val};
  assign diff_neg  = -diff;
  assign mag       = diff[VALUE_BITS] ? diff_neg[VALUE_BITS-1:0] : diff[VALUE_BITS-1:0];
  assign wrap_dist = ~mag + 1'b1;
  assign lead_dist = (circular && mag[VALUE_BITS-1]) ? wrap_dist : mag;

  // pipeline stages
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else begin
      p1_valid <= cmd.scan_issue;
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    p1_addr <= scan_cnt[IW-1:0];
    p2_addr <= p1_addr;
    p2_dist <= lead_dist;
    p2_cnt  <= count_q;
  end

  // match test and saturating increment
  assign hit     = p2_valid && (p2_dist < threshold);
  assign bump_we = hit && (p2_cnt != CNT_MAX);
  assign bumped  = p2_cnt + 1'b1;

  // match bookkeeping: none, one or several
  always_ff @(posedge clk) begin
    if (rst) begin
      match_n <= '0;
    end else if (cmd.scan_clear) begin
      match_n <= '0;
    end else if (hit) begin
      if (match_n != 2'd2) begin
        match_n <= match_n + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hit && (match_n == 2'd0)) begin
      first_idx <= p2_addr;
    end
  end

  // outcome of the current word
  always_comb begin
    res_status = ST_IGNORED;
    res_idx    = '0;
    res_val    = '0;
    res_cnt    = '0;
    add_new    = 1'b0;
    set_stop   = 1'b0;
    if (item_op == OP_READ) begin
      res_status = ST_READ_DONE;
      res_idx    = item_idx;
      if (TW'(item_idx) < total) begin
        res_val = leader_q;
        res_cnt = count_q;
      end
    end else if (stop) begin
      res_status = ST_IGNORED;
    end else if (match_n == 2'd0) begin
      if (total >= TW'(MAX_CLUSTERS)) begin
        res_status = ST_FULL;
      end else begin
        res_status = ST_NEW;
        res_idx    = total[IW-1:0];
        add_new    = 1'b1;
      end
    end else if (match_n == 2'd1) begin
      res_status = ST_JOINED;
      res_idx    = first_idx;
    end else begin
      res_status = ST_AMBIGUOUS;
      res_idx    = first_idx;
      set_stop   = 1'b1;
    end
  end

  // running totals and the sticky flag
  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      tally <= '0;
      stop  <= 1'b0;
    end else begin
      if (cmd.finish && add_new) begin
        total <= total + 1'b1;
      end
      if (cmd.finish && set_stop) begin
        stop <= 1'b1;
      end
      for (int k = 0; k < NUM_TALLIES; k++) begin
        if ((bump_we && (bumped == COUNT_BITS'(TALLY_LIMITS[k]))) ||
            (cmd.finish && add_new && (TALLY_LIMITS[k] <= 1))) begin
          tally[k] <= tally[k] + 1'b1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status         <= res_status;
      out_cluster_index  <= res_idx;
      out_entry_value    <= res_val;
      out_entry_count    <= res_cnt;
      out_clusters_total <= total + TW'(add_new);
      for (int k = 0; k < NUM_TALLIES; k++) begin
        out_tallies[k] <= tally[k] + TW'(add_new && (TALLY_LIMITS[k] <= 1));
      end
      out_not_converged  <= stop | set_stop;
    end
  end

  // status to the controller
  assign stat.op_read   = (item_op == OP_READ);
  assign stat.stop      = stop;
  assign stat.scan_done = (scan_cnt == total);
  assign stat.busy      = p1_valid | p2_valid;
  assign stat.out_free  = !out_valid || out_ready;

endmodule

`default_nettype wire

// ===== hdl/threshold_leader_clustering.sv =====
// ----------------------------------------------------------------------------
// threshold_leader_clustering
// add: the word is compared against every stored leader in turn, by the
// one-leader-per-cycle table scan through a single read port; a new word is
// taken only once the result of the last one is registered, for reads as for adds
// rst (sync, high) clears totals, tallies, not-converged flag, control and config registers;
// table contents are not cleared and are only reported below the cluster total
// ----------------------------------------------------------------------------
`default_nettype none

module threshold_leader_clustering
  import tlc_pkg::*;
#(
  parameter int unsigned MAX_CLUSTERS = 64,
  parameter int unsigned VALUE_BITS   = 16,
  parameter int unsigned COUNT_BITS   = 20,
  localparam int unsigned IW  = $clog2(MAX_CLUSTERS),
  localparam int unsigned TW  = $clog2(MAX_CLUSTERS + 1),
  localparam int unsigned IDW = ((VALUE_BITS + IW + 7) / 8) * 8,
  localparam int unsigned ODW = ((IW + VALUE_BITS + COUNT_BITS + 5 * TW + 1 + 7) / 8) * 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // configuration write port
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [VALUE_BITS-1:0]     cfg_data,
  // input words
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [IDW-1:0]            s_axis_tdata,  // opinion, entry_index, zero pad
  input  wire logic                      s_axis_tuser,  // opcode
  // result words
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  output logic [ODW-1:0]                 m_axis_tdata,  // cluster_index, entry_value,
                                                        // entry_count, clusters_total,
                                                        // clusters_ge10, clusters_ge20,
                                                        // clusters_ge50, clusters_ge100,
                                                        // not_converged, zero pad
  output logic [2:0]                     m_axis_tuser   // status
);

  ctl_cmd_t                      cmd;
  dp_status_t                    stat;
  status_t                       out_status;
  logic [IW-1:0]                 out_cluster_index;
  logic [VALUE_BITS-1:0]         out_entry_value;
  logic [COUNT_BITS-1:0]         out_entry_count;
  logic [TW-1:0]                 out_clusters_total;
  logic [NUM_TALLIES-1:0][TW-1:0] out_tallies;
  logic                          out_not_converged;

  // sequencer
  tlc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // tables, compare pipeline and result register
  tlc_datapath #(
    .MAX_CLUSTERS (MAX_CLUSTERS),
    .VALUE_BITS   (VALUE_BITS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_opcode          (s_axis_tuser),
    .in_opinion         (s_axis_tdata[VALUE_BITS-1:0]),
    .in_entry_index     (s_axis_tdata[VALUE_BITS+IW-1:VALUE_BITS]),
    .cmd                (cmd),
    .stat               (stat),
    .out_valid          (m_axis_tvalid),
    .out_ready          (m_axis_tready),
    .out_status         (out_status),
    .out_cluster_index  (out_cluster_index),
    .out_entry_value    (out_entry_value),
    .out_entry_count    (out_entry_count),
    .out_clusters_total (out_clusters_total),
    .out_tallies        (out_tallies),
    .out_not_converged  (out_not_converged)
  );

  // result word packing, first field in the lowest bits
  assign m_axis_tdata = ODW'({out_not_converged,
                              out_tallies[3], out_tallies[2],
                              out_tallies[1], out_tallies[0],
                              out_clusters_total,
                              out_entry_count,
                              out_entry_value,
                              out_cluster_index});
  assign m_axis_tuser = out_status;

endmodule

`default_nettype wire

// ===== hdl/tlc_checker.sv =====
// ----------------------------------------------------------------------------
// tlc_checker
// port-level checks of the clustering block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "threshold_leader_clustering_macros.svh"

module tlc_checker
  import tlc_pkg::*;
#(
  parameter int unsigned MAX_CLUSTERS = 64,
  parameter int unsigned VALUE_BITS   = 16,
  parameter int unsigned COUNT_BITS   = 20,
  localparam int unsigned IW  = $clog2(MAX_CLUSTERS),
  localparam int unsigned TW  = $clog2(MAX_CLUSTERS + 1),
  localparam int unsigned ODW = ((IW + VALUE_BITS + COUNT_BITS + 5 * TW + 1 + 7) / 8) * 8,
  localparam int unsigned TOTAL_LO = IW + VALUE_BITS + COUNT_BITS,
  localparam int unsigned NC_BIT   = TOTAL_LO + 5 * TW
) (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           s_axis_tvalid,
  input wire logic           s_axis_tready,
  input wire logic           m_axis_tvalid,
  input wire logic           m_axis_tready,
  input wire logic [ODW-1:0] m_axis_tdata,
  input wire logic [2:0]     m_axis_tuser
);

  logic          nc;
  logic [IW-1:0] cidx;
  logic [TW-1:0] ctotal;

  assign nc     = m_axis_tdata[NC_BIT];
  assign cidx   = m_axis_tdata[IW-1:0];
  assign ctotal = m_axis_tdata[TOTAL_LO+TW-1:TOTAL_LO];

  // a stalled result holds
  `TLC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // a taken word leaves the block not ready in the next cycle
  `TLC_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready right after accept")

  // not-converged is sticky
  `TLC_ASSERT_NEXT(a_nc_sticky, m_axis_tvalid && nc, nc, "not-converged flag dropped")

  // ambiguous and ignored outcomes only with the flag set
  `TLC_ASSERT_SAME(a_nc_status, m_axis_tvalid && (m_axis_tuser == ST_AMBIGUOUS || m_axis_tuser == ST_IGNORED), nc, "flag clear on ambiguous or ignored")

  // a new cluster is the last one in the table
  `TLC_ASSERT_SAME(a_new_index, m_axis_tvalid && m_axis_tuser == ST_NEW, TW'(cidx) + 1'b1 == ctotal, "new cluster index off the total")

endmodule

bind threshold_leader_clustering tlc_checker #(
  .MAX_CLUSTERS (MAX_CLUSTERS),
  .VALUE_BITS   (VALUE_BITS),
  .COUNT_BITS   (COUNT_BITS)
) u_tlc_checker (.*);

`default_nettype wire

// ===== verif/threshold_leader_clustering_chk.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// threshold_leader_clustering_chk
// watches the config port and both streams, keeps its own copy of the leader
// table, predicts each result word and compares it field by field
// ----------------------------------------------------------------------------

module threshold_leader_clustering_chk
  import tlc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [15:0]               cfg_data,
  input  logic                      s_axis_tvalid,
  input  logic                      s_axis_tready,
  input  logic [23:0]               s_axis_tdata,  // opinion, entry_index, zero pad
  input  logic                      s_axis_tuser,  // opcode
  input  logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  input  logic [79:0]               m_axis_tdata,  // cluster_index, entry_value, entry_count,
                                                   // clusters_total, clusters_ge10,
                                                   // clusters_ge20, clusters_ge50,
                                                   // clusters_ge100, not_converged, zero pad
  input  logic [2:0]                m_axis_tuser,  // status
  output int                        fail_count,
  output int                        pending
);

  localparam int MAX_CLUSTERS = 64;
  localparam int ONE          = 65536;
  localparam int HALF         = 32768;
  localparam logic [19:0] COUNT_MAX = 20'hFFFFF;

  // result word field offsets
  localparam int EVAL_LSB = 6;
  localparam int ECNT_LSB = 22;
  localparam int TOT_LSB  = 42;
  localparam int GE10_LSB = 49;
  localparam int GE20_LSB = 56;
  localparam int GE50_LSB = 63;
  localparam int GE100_LSB = 70;
  localparam int NC_BIT   = 77;

  typedef struct packed {
    status_t     status;
    logic [5:0]  cluster_index;
    logic [15:0] entry_value;
    logic [19:0] entry_count;
    logic [6:0]  clusters_total;
    logic [6:0]  clusters_ge10;
    logic [6:0]  clusters_ge20;
    logic [6:0]  clusters_ge50;
    logic [6:0]  clusters_ge100;
    logic        not_converged;
  } cluster_word_t;

  // shadow of the block state
  logic [15:0]  threshold_q;
  logic         circular_q;
  logic [15:0]  leader_q [MAX_CLUSTERS];
  logic [19:0]  member_q [MAX_CLUSTERS];
  int unsigned  n_clusters;
  int unsigned  size_tally [NUM_TALLIES];
  bit           stopped;

  cluster_word_t expected_words [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // linear or wrap-around distance between a leader and an opinion
  function automatic int opinion_distance(input logic [15:0] lead, input logic [15:0] val);
    int d;
    d = int'(lead) - int'(val);
    if (circular_q) begin
      if (d >= HALF) d = ONE - d;
      else if (d < 0) d = (d > -HALF) ? -d : ONE + d;
      return d;
    end
    return (d < 0) ? -d : d;
  endfunction

  // apply one input word to the shadow table and build the result word
  function automatic cluster_word_t cluster_opinion(input logic op, input logic [15:0] val,
                                                    input logic [5:0] idx);
    cluster_word_t r;
    int unsigned hits;
    int unsigned first;
    r = '0;
    hits = 0;
    first = 0;
    if (op == OP_READ) begin
      r.status = ST_READ_DONE;
      r.cluster_index = idx;
      if (idx < n_clusters) begin
        r.entry_value = leader_q[idx];
        r.entry_count = member_q[idx];
      end
    end else if (stopped) begin
      r.status = ST_IGNORED;
    end else begin
      // every leader in range gets the member, saturating
      for (int unsigned j = 0; j < n_clusters; j++) begin
        if (opinion_distance(leader_q[j], val) < int'(threshold_q)) begin
          if (hits == 0) first = j;
          hits++;
          if (member_q[j] != COUNT_MAX) begin
            member_q[j]++;
            for (int k = 0; k < NUM_TALLIES; k++)
              if (member_q[j] == TALLY_LIMITS[k]) size_tally[k]++;
          end
        end
      end
      if (hits == 0) begin
        if (n_clusters >= MAX_CLUSTERS) begin
          r.status = ST_FULL;
        end else begin
          leader_q[n_clusters] = val;
          member_q[n_clusters] = 20'd1;
          for (int k = 0; k < NUM_TALLIES; k++)
            if (TALLY_LIMITS[k] <= 1) size_tally[k]++;
          r.status = ST_NEW;
          r.cluster_index = 6'(n_clusters);
          n_clusters++;
        end
      end else if (hits == 1) begin
        r.status = ST_JOINED;
        r.cluster_index = 6'(first);
      end else begin
        r.status = ST_AMBIGUOUS;
        r.cluster_index = 6'(first);
        stopped = 1'b1;
      end
    end
    r.clusters_total = 7'(n_clusters);
    r.clusters_ge10  = 7'(size_tally[0]);
    r.clusters_ge20  = 7'(size_tally[1]);
    r.clusters_ge50  = 7'(size_tally[2]);
    r.clusters_ge100 = 7'(size_tally[3]);
    r.not_converged  = stopped;
    return r;
  endfunction

  task automatic compare_field(input string name, input longint unsigned want,
                               input longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // sample both channels and the config port at the clock edge
  always @(posedge clk) begin : watch
    cluster_word_t want;
    cluster_word_t pred;
    if (rst) begin
      threshold_q = 16'(THRESHOLD_RESET);
      circular_q  = CIRCULAR_RESET;
      n_clusters  = 0;
      for (int k = 0; k < NUM_TALLIES; k++) size_tally[k] = 0;
      stopped = 1'b0;
      expected_words.delete();
    end else begin
      // result word against the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_words.size() == 0) begin
          $error("result word with no prediction waiting");
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          compare_field("status", want.status, m_axis_tuser);
          compare_field("cluster_index", want.cluster_index, m_axis_tdata[5:0]);
          compare_field("entry_value", want.entry_value, m_axis_tdata[EVAL_LSB +: 16]);
          compare_field("entry_count", want.entry_count, m_axis_tdata[ECNT_LSB +: 20]);
          compare_field("clusters_total", want.clusters_total, m_axis_tdata[TOT_LSB +: 7]);
          compare_field("clusters_ge10", want.clusters_ge10, m_axis_tdata[GE10_LSB +: 7]);
          compare_field("clusters_ge20", want.clusters_ge20, m_axis_tdata[GE20_LSB +: 7]);
          compare_field("clusters_ge50", want.clusters_ge50, m_axis_tdata[GE50_LSB +: 7]);
          compare_field("clusters_ge100", want.clusters_ge100, m_axis_tdata[GE100_LSB +: 7]);
          compare_field("not_converged", want.not_converged, m_axis_tdata[NC_BIT]);
        end
      end
      // accepted input word
      if (s_axis_tvalid && s_axis_tready) begin
        pred = cluster_opinion(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[21:16]);
        expected_words = {expected_words, pred};
      end
      // register writes
      if (cfg_we) begin
        if (cfg_index == REG_THRESHOLD) threshold_q = cfg_data;
        else if (cfg_index == REG_CIRCULAR) circular_q = cfg_data[0];
      end
    end
    pending = expected_words.size();
  end

endmodule

// ===== verif/threshold_leader_clustering_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// threshold_leader_clustering_tb
// drives opinion and read words through phases of linear and wrap-around
// distance; most adds land near a fixed grid of centers so clusters grow
// past every size tally before the table is filled and convergence is lost
// ----------------------------------------------------------------------------

module threshold_leader_clustering_tb;
  import tlc_pkg::*;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [15:0]               cfg_data = '0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [23:0]               s_axis_tdata = '0;  // opinion, entry_index, zero pad
  logic                      s_axis_tuser = 1'b0;  // opcode
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [79:0]               m_axis_tdata;  // cluster_index, entry_value, entry_count,
                                            // clusters_total, clusters_ge10, clusters_ge20,
                                            // clusters_ge50, clusters_ge100, not_converged
  logic [2:0]                m_axis_tuser;  // status

  int fail_count;
  int pending;

  // sender burst state and receiver hold-off request
  int unsigned burst_left = 0;
  bit          hold_request = 1'b0;

  // centers that member opinions are drawn around
  int unsigned grid_centers [$];
  int unsigned grid_half;

  threshold_leader_clustering uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  threshold_leader_clustering_chk u_chk (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("threshold_leader_clustering regression: fail");
    $finish;
  end

  // receiver: random stall stretches, ready stretches, and a long hold-off on request
  initial begin : receiver
    int unsigned hold_left;
    int unsigned mode_left;
    int unsigned stall_pct;
    hold_left = 0;
    mode_left = 0;
    stall_pct = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          case ($urandom_range(0, 2))
            0: stall_pct = 0;
            1: stall_pct = 25;
            default: stall_pct = 75;
          endcase
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // offer one word, with a random gap between bursts, and wait for acceptance
  task automatic send_word(input logic op, input logic [15:0] val, input logic [5:0] idx);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      repeat (gap) begin
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
      end
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, idx, val};
    s_axis_tuser  <= op;
    burst_left--;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // stop offering and wait until every predicted word has come back
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // centers 4 thresholds apart, clear of the directed leaders
  task automatic build_grid(input int unsigned thr);
    int unsigned c;
    grid_centers.delete();
    grid_half = thr / 2 - 1;
    for (c = 5000; c <= 28000; c += 4 * thr) grid_centers = {grid_centers, c};
    for (c = 40000; c <= 60500; c += 4 * thr) grid_centers = {grid_centers, c};
  endtask

  // opinion within half a threshold of a center, the first few centers favored
  function automatic logic [15:0] member_opinion();
    int unsigned k;
    k = ($urandom_range(0, 99) < 60) ? $urandom_range(0, 2)
                                     : $urandom_range(0, grid_centers.size() - 1);
    return 16'(grid_centers[k] + $urandom_range(0, 2 * grid_half) - grid_half);
  endfunction

  // random mix of member adds, free adds and reads
  task automatic send_mix(input int unsigned count, input int unsigned member_pct,
                          input int unsigned free_pct);
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < member_pct)
        send_word(OP_ADD, member_opinion(), 6'($urandom));
      else if (pick < member_pct + free_pct)
        send_word(OP_ADD, 16'($urandom), 6'($urandom));
      else
        send_word(OP_READ, 16'($urandom), 6'($urandom));
    end
  endtask

  // stimulus
  initial begin : stimulus
    int unsigned grid_thr;
    grid_thr = $urandom_range(300, 700);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings, linear: empty reads, field extremes, threshold edge
    send_word(OP_READ, 16'hFFFF, 6'd0);
    send_word(OP_READ, 16'h0000, 6'd63);
    send_word(OP_ADD, 16'd0, 6'd63);
    send_word(OP_ADD, 16'd65535, 6'd0);
    send_word(OP_ADD, 16'd32768, 6'd0);
    send_word(OP_ADD, 16'd36045, 6'd0);   // exactly one threshold away, new cluster
    send_word(OP_ADD, 16'd3276, 6'd0);    // one below the threshold, joins
    send_word(OP_ADD, 16'd29492, 6'd0);
    send_word(OP_READ, 16'd0, 6'd2);
    send_word(OP_READ, 16'd0, 6'd4);      // beyond the stored clusters
    send_word(OP_READ, 16'd0, 6'd0);
    settle();

    // wrap-around distance, grid members, long receiver hold-off early on
    write_reg(REG_THRESHOLD, 16'(grid_thr));
    write_reg(REG_CIRCULAR, 16'd1);
    build_grid(grid_thr);
    hold_request = 1'b1;
    send_mix(450, 82, 0);
    settle();

    // same grid, linear distance
    write_reg(REG_CIRCULAR, 16'd0);
    send_mix(250, 82, 0);
    settle();

    // zero threshold: nothing matches, table fills and then drops words
    write_reg(REG_THRESHOLD, 16'd0);
    send_mix(70, 0, 85);
    settle();

    // grid threshold again over a full table, with free adds as noise
    write_reg(REG_THRESHOLD, 16'(grid_thr));
    send_mix(100, 50, 30);
    settle();

    // widest threshold, wrap-around: the first add matches many, then adds are ignored
    write_reg(REG_THRESHOLD, 16'hFFFF);
    write_reg(REG_CIRCULAR, 16'd1);
    send_word(OP_ADD, 16'd0, 6'd0);
    send_word(OP_ADD, 16'd65535, 6'd0);
    repeat (8) send_word(OP_ADD, 16'($urandom), 6'($urandom));
    for (int i = 0; i < 64; i++) send_word(OP_READ, 16'($urandom), 6'(i));
    settle();

    repeat (100) @(negedge clk);
    if (fail_count == 0)
      $display("threshold_leader_clustering regression: pass");
    else
      $display("threshold_leader_clustering regression: fail");
    $finish;
  end

endmodule

// ===== threshold_leader_clustering.f =====
+incdir+hdl
hdl/tlc_pkg.sv
hdl/tlc_ctrl.sv
hdl/tlc_datapath.sv
hdl/threshold_leader_clustering.sv
hdl/tlc_checker.sv
verif/threshold_leader_clustering_chk.sv
verif/threshold_leader_clustering_tb.sv
